// ===== rtl/core/fbct_pkg.sv =====
// ----------------------------------------------------------------------------
// fbct_pkg: shared types and constants for the frustum box cull test
// Command codes, fixed-point sizes, sequencer states and the queue entry
// carried front to back.
// ----------------------------------------------------------------------------
package fbct_pkg;

    localparam int NUM_PLANES = 6;
    localparam int FRAC_BITS  = 16;
    localparam int PLANE_W    = $clog2(NUM_PLANES);
    // three 32x33 products plus a scaled 32-bit term, with headroom
    localparam int ACC_W      = 68;

    typedef enum logic [1:0] {
        CMD_LOAD_PLANE = 2'd0,
        CMD_LOAD_ROW   = 2'd1,
        CMD_TEST       = 2'd2,
        CMD_NONE       = 2'd3
    } cmd_t;

    // plane walk sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_XFORM,
        ST_DIST,
        ST_OUT
    } back_st_t;

    // one queued box test
    typedef struct packed {
        logic signed [2:0][31:0] mn;
        logic signed [2:0][31:0] mx;
        logic signed [2:0][31:0] ce;
    } box_t;

    // input word packing: slot, then ten 32-bit fields, padded to whole bytes
    localparam int IN_W = 328;

endpackage

// ===== rtl/core/frustum_box_cull_test.sv =====
// ----------------------------------------------------------------------------
// frustum_box_cull_test: top level
// Front end decodes words and queues box tests; back end walks the planes.
// ----------------------------------------------------------------------------
//  group  dir  handshake            payload, lowest bit first
//  s_t*   in   s_tvalid, s_tready   tuser: cmd; tdata: slot, a_x, a_y, a_z,
//                                   a_w, b_x, b_y, b_z, c_x, c_y, c_z, 5 zeros
//  m_t*   out  m_tvalid, m_tready   tdata: visible, 7 zeros
//
// One 32x33 multiplier; a test walks P = 1..6 planes. The back end takes one
// test at a time and accepts the next only after the result has been taken.
// A two-entry queue takes tests while the back end works; loads wait until the
// queue is empty and the back end is idle.
// The result is held until m_tready. rst_n clears the queue and sequencer only.
// ----------------------------------------------------------------------------
module frustum_box_cull_test
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [1:0]                  s_tuser,   // cmd
    input  logic [fbct_pkg::IN_W-1:0]   s_tdata,   // slot, a_x..a_w, b_x..b_z, c_x..c_z
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // visible, zero padding
);
    import fbct_pkg::*;

    logic q_valid;
    logic q_ready;
    logic back_idle;
    logic res_visible;
    box_t q_box;
    logic [NUM_PLANES-1:0][3:0][31:0] planes;
    logic [2:0][3:0][31:0] rows;

    fbct_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_data   (s_tdata),
        .back_idle (back_idle),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_box     (q_box),
        .planes    (planes),
        .rows      (rows)
    );

    fbct_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_box       (q_box),
        .planes      (planes),
        .rows        (rows),
        .idle        (back_idle),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_visible (res_visible)
    );

    // pad the verdict to a byte
    assign m_tdata = {7'd0, res_visible};

endmodule

// ===== rtl/core/fbct_front.sv =====
// ----------------------------------------------------------------------------
// fbct_front: command decode, plane and transform stores, test queue
// Loads write the stores; tests go into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fbct_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      in_cmd,
    input  logic [fbct_pkg::IN_W-1:0]       in_data,
    input  logic                            back_idle,
    // queue to back end
    output logic                            q_valid,
    input  logic                            q_ready,
    output fbct_pkg::box_t                  q_box,
    // stores, read by the back end
    output logic [fbct_pkg::NUM_PLANES-1:0][3:0][31:0] planes,
    output logic [2:0][3:0][31:0]           rows
);
    import fbct_pkg::*;

    cmd_t cmd;
    logic [2:0] slot;
    logic [31:0] f [10];
    box_t  box_in;
    box_t  q_reg [2];
    logic  [1:0] cnt_reg, cnt_next;
    logic  wr_ptr_reg, rd_ptr_reg;
    logic  push, pop, take;
    logic [NUM_PLANES-1:0][3:0][31:0] planes_reg;
    logic [2:0][3:0][31:0] rows_reg;

    // unpack the word
    assign cmd  = cmd_t'(in_cmd);
    assign slot = in_data[2:0];
    always_comb
    begin
        for (int k = 0; k < 10; k++)
        begin
            f[k] = in_data[3 + 32*k +: 32];
        end
    end
    assign box_in.mn = {f[2], f[1], f[0]};
    assign box_in.mx = {f[6], f[5], f[4]};
    assign box_in.ce = {f[9], f[8], f[7]};

    // hold loads until no test is queued or running
    always_comb
    begin
        unique case (cmd)
            CMD_TEST:       in_ready = cnt_reg != 2'd2;
            CMD_LOAD_PLANE: in_ready = (cnt_reg == 2'd0) && back_idle;
            CMD_LOAD_ROW:   in_ready = (cnt_reg == 2'd0) && back_idle;
            CMD_NONE:       in_ready = 1'b1;
        endcase
    end

    assign take     = in_valid && in_ready;
    assign push     = take && (cmd == CMD_TEST);
    assign pop      = q_valid && q_ready;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_box    = q_reg[rd_ptr_reg];
    assign planes   = planes_reg;
    assign rows     = rows_reg;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // store queue entries and loads; drop loads to slots out of range
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= box_in;
        end
        if (take && cmd == CMD_LOAD_PLANE && {1'b0, slot} < 4'(NUM_PLANES))
        begin
            planes_reg[slot[PLANE_W-1:0]] <= {f[3], f[2], f[1], f[0]};
        end
        if (take && cmd == CMD_LOAD_ROW && slot < 3'd3)
        begin
            rows_reg[slot[1:0]] <= {f[3], f[2], f[1], f[0]};
        end
    end

endmodule

// ===== rtl/core/fbct_back.sv =====
// ----------------------------------------------------------------------------
// fbct_back: plane walk sequencer with one shared multiply-accumulate
// Each plane takes three axis sums, three transform rows and one distance
// sum, each made of three products and one closing step.
// ----------------------------------------------------------------------------
module fbct_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  fbct_pkg::box_t                  q_box,
    input  logic [fbct_pkg::NUM_PLANES-1:0][3:0][31:0] planes,
    input  logic [2:0][3:0][31:0]           rows,
    output logic                            idle,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic                            res_visible
);
    import fbct_pkg::*;

    back_st_t st_reg, st_next;
    logic [PLANE_W-1:0] p_reg, p_next;
    logic [1:0] n_reg, n_next, k_reg, k_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [32:0] corner_reg [3];
    logic signed [32:0] corner_next [3];
    logic signed [31:0] world_reg [3];
    logic signed [31:0] world_next [3];
    logic vis_reg, vis_next;
    box_t box_reg, box_next;
    // product operands, closing term and derived sums
    logic signed [31:0] op_a;
    logic signed [32:0] op_b;
    logic signed [64:0] prod;
    logic signed [31:0] term;
    logic signed [ACC_W-1:0] acc_mac;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] sum_shift;
    logic signed [31:0] sum_sat;
    logic acc_pos;
    logic mac_step;

    assign res_valid   = st_reg == ST_OUT;
    assign res_visible = vis_reg;
    assign q_ready     = st_reg == ST_IDLE;
    assign idle        = st_reg == ST_IDLE;
    assign mac_step    = k_reg != 2'd3;

    // select operands for the current step
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        term = '0;
        unique case (st_reg)
            ST_AXIS:
            begin
                // row[i][j] * normal[i], summed over i
                if (mac_step)
                begin
                    op_a = $signed(rows[k_reg][n_reg]);
                    op_b = 33'($signed(planes[p_reg][k_reg]));
                end
            end
            ST_XFORM:
            begin
                // row[i][j] * corner[j], summed over j, plus translation
                term = $signed(rows[n_reg][3]);
                if (mac_step)
                begin
                    op_a = $signed(rows[n_reg][k_reg]);
                    op_b = corner_reg[k_reg];
                end
            end
            ST_DIST:
            begin
                // normal[i] * world[i], summed over i, plus offset
                term = $signed(planes[p_reg][3]);
                if (mac_step)
                begin
                    op_a = $signed(planes[p_reg][k_reg]);
                    op_b = 33'(world_reg[k_reg]);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign prod      = op_a * op_b;
    assign acc_mac   = acc_reg + ACC_W'(prod);
    assign sum       = acc_reg + (ACC_W'(term) <<< FRAC_BITS);
    assign sum_shift = sum >>> FRAC_BITS;
    assign acc_pos   = !acc_reg[ACC_W-1] && (acc_reg != '0);

    // floor shift and saturate a transform sum
    always_comb
    begin
        if (!sum_shift[ACC_W-1] && (|sum_shift[ACC_W-2:31]))
            sum_sat = 32'sh7FFF_FFFF;
        else if (sum_shift[ACC_W-1] && !(&sum_shift[ACC_W-2:31]))
            sum_sat = 32'sh8000_0000;
        else
            sum_sat = sum_shift[31:0];
    end

    // sequence the walk
    always_comb
    begin
        st_next     = st_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        corner_next = corner_reg;
        world_next  = world_reg;
        vis_next    = vis_reg;
        box_next    = box_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    st_next  = ST_AXIS;
                    p_next   = '0;
                    n_next   = '0;
                    k_next   = '0;
                    acc_next = '0;
                    box_next = q_box;
                end
            end
            ST_AXIS:
            begin
                if (mac_step)
                begin
                    acc_next = acc_mac;
                    k_next   = k_reg + 2'd1;
                end
                else
                begin
                    // positive sum picks the maximum extent, else the minimum
                    corner_next[n_reg] = 33'($signed(box_reg.ce[n_reg])) +
                        (acc_pos ? 33'($signed(box_reg.mx[n_reg]))
                                 : 33'($signed(box_reg.mn[n_reg])));
                    acc_next = '0;
                    k_next   = '0;
                    if (n_reg == 2'd2)
                    begin
                        n_next  = '0;
                        st_next = ST_XFORM;
                    end
                    else
                    begin
                        n_next = n_reg + 2'd1;
                    end
                end
            end
            ST_XFORM:
            begin
                if (mac_step)
                begin
                    acc_next = acc_mac;
                    k_next   = k_reg + 2'd1;
                end
                else
                begin
                    world_next[n_reg] = sum_sat;
                    acc_next = '0;
                    k_next   = '0;
                    if (n_reg == 2'd2)
                    begin
                        n_next  = '0;
                        st_next = ST_DIST;
                    end
                    else
                    begin
                        n_next = n_reg + 2'd1;
                    end
                end
            end
            ST_DIST:
            begin
                if (mac_step)
                begin
                    acc_next = acc_mac;
                    k_next   = k_reg + 2'd1;
                end
                else
                begin
                    acc_next = '0;
                    k_next   = '0;
                    // negative distance rejects; zero passes
                    priority if (sum[ACC_W-1])
                    begin
                        vis_next = 1'b0;
                        st_next  = ST_OUT;
                    end
                    else if (p_reg == PLANE_W'(NUM_PLANES - 1))
                    begin
                        vis_next = 1'b1;
                        st_next  = ST_OUT;
                    end
                    else
                    begin
                        p_next  = p_reg + 1'b1;
                        st_next = ST_AXIS;
                    end
                end
            end
            ST_OUT:
            begin
                // hold the verdict until taken
                if (res_ready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            p_reg      <= '0;
            n_reg      <= '0;
            k_reg      <= '0;
            acc_reg    <= '0;
            corner_reg <= '{default: '0};
            world_reg  <= '{default: '0};
            vis_reg    <= 1'b0;
            box_reg    <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            p_reg      <= p_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            acc_reg    <= acc_next;
            corner_reg <= corner_next;
            world_reg  <= world_next;
            vis_reg    <= vis_next;
            box_reg    <= box_next;
        end
    end

endmodule
